### rtl/wtr_pkg.sv
package wtr_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int PTR_W        = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W        = PTR_W + 1;

   localparam int TS_W     = 32;
   localparam int SCORE_W  = 16;
   localparam int TOTAL_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int RATIO_W  = FRAC_W + 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_HIT_THRESHOLD = CSR_INDEX_W'(1);

   localparam logic [TS_W-1:0]    WINDOW_LENGTH_RESET = TS_W'(1000);
   localparam logic [SCORE_W-1:0] HIT_THRESHOLD_RESET = SCORE_W'(19660);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX           = '1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int DIV_STEPS = RATIO_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [TS_W-1:0] timestamp;
      logic            hit;
   } sample_type;

   typedef struct packed {
      logic       valid;
      sample_type sample;
   } queue_out_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_FULL,
      BACK_SETTLE,
      BACK_PRUNE,
      BACK_WDIV,
      BACK_GDIV,
      BACK_EMIT
   } back_state_type;

endpackage

### rtl/wtr_req_if.sv
interface wtr_req_if;
   logic                         valid;
   logic                         ready;
   logic [wtr_pkg::TS_W-1:0]     timestamp_ms;
   logic [wtr_pkg::SCORE_W-1:0]  score;

   modport source (output valid, output timestamp_ms, output score, input ready);
   modport sink   (input valid, input timestamp_ms, input score, output ready);
endinterface

### rtl/wtr_rsp_if.sv
interface wtr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wtr_pkg::RATIO_W-1:0]  window_ratio;
   logic [wtr_pkg::RATIO_W-1:0]  global_ratio;
   logic [wtr_pkg::CNT_W-1:0]    window_samples;
   logic [wtr_pkg::CNT_W-1:0]    window_hits;
   logic                         overflow;

   modport source (output valid, output window_ratio, output global_ratio,
                   output window_samples, output window_hits, output overflow,
                   input ready);
   modport sink   (input valid, input window_ratio, input global_ratio,
                   input window_samples, input window_hits, input overflow,
                   output ready);
endinterface

### rtl/wtr_ram.sv
module wtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/wtr_div.sv
module wtr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wtr_pkg::TOTAL_W-1:0]   numer,
   input  logic [wtr_pkg::TOTAL_W-1:0]   denom,
   output logic                          done,
   output logic [wtr_pkg::RATIO_W-1:0]   quotient
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [wtr_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [wtr_pkg::TOTAL_W-1:0]     rem_ff, rem_in;
   logic [wtr_pkg::TOTAL_W-1:0]     denom_ff, denom_in;
   logic [wtr_pkg::RATIO_W-1:0]     quot_ff, quot_in;
   logic [wtr_pkg::TOTAL_W:0]       trial;
   logic [wtr_pkg::TOTAL_W:0]       diff;
   logic                            ge;

   always_comb begin
      trial = (cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff  = trial - {1'b0, denom_ff};
      ge    = trial >= {1'b0, denom_ff};
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      quot_in  = quot_ff;
      if (busy_ff) begin
         rem_in  = ge ? diff[wtr_pkg::TOTAL_W-1:0] : trial[wtr_pkg::TOTAL_W-1:0];
         quot_in = {quot_ff[wtr_pkg::RATIO_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == wtr_pkg::DIV_CNT_W'(wtr_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         rem_in   = numer;
         denom_in = denom;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
      quot_ff  <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
`endif

endmodule

### rtl/wtr_front.sv
module wtr_front (
   input  logic                          clock,
   input  logic                          reset,
   wtr_req_if.sink                       req_chan,
   input  logic [wtr_pkg::SCORE_W-1:0]   hit_threshold,
   input  logic                          pop,
   output wtr_pkg::queue_out_type        queue_out
);

   wtr_pkg::sample_type           slot_ff [wtr_pkg::QUEUE_DEPTH];
   logic [wtr_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [wtr_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [wtr_pkg::QCNT_W-1:0]    count_ff, count_in;
   wtr_pkg::sample_type           incoming;
   logic                          push;
   logic                          pop_ok;

   assign req_chan.ready = count_ff != wtr_pkg::QCNT_W'(wtr_pkg::QUEUE_DEPTH);
   assign push           = req_chan.valid && req_chan.ready;
   assign pop_ok         = pop && (count_ff != '0);

   always_comb begin
      incoming.timestamp = req_chan.timestamp_ms;
      incoming.hit       = req_chan.score > hit_threshold;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == wtr_pkg::QPTR_W'(wtr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == wtr_pkg::QPTR_W'(wtr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

   always_comb begin
      queue_out.valid  = count_ff != '0;
      queue_out.sample = slot_ff[rd_ptr_ff];
   end

endmodule

### rtl/wtr_back.sv
module wtr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  wtr_pkg::queue_out_type        queue_out,
   output logic                          pop,
   input  logic [wtr_pkg::TS_W-1:0]      window_length,
   wtr_rsp_if.source                     rsp_chan
);

   wtr_pkg::back_state_type          state_ff, state_in;
   wtr_pkg::sample_type              cur_ff, cur_in;
   logic                             over_ff, over_in;
   logic [wtr_pkg::PTR_W-1:0]        head_ptr_ff, head_ptr_in;
   logic [wtr_pkg::CNT_W-1:0]        occ_ff, occ_in;
   logic [wtr_pkg::CNT_W-1:0]        hits_ff, hits_in;
   logic [wtr_pkg::TOTAL_W-1:0]      total_samples_ff, total_samples_in;
   logic [wtr_pkg::TOTAL_W-1:0]      total_hits_ff, total_hits_in;
   logic [wtr_pkg::RATIO_W-1:0]      window_ratio_ff, window_ratio_in;
   logic [wtr_pkg::RATIO_W-1:0]      global_ratio_ff, global_ratio_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [wtr_pkg::RATIO_W-1:0]      rsp_window_ratio_ff, rsp_window_ratio_in;
   logic [wtr_pkg::RATIO_W-1:0]      rsp_global_ratio_ff, rsp_global_ratio_in;
   logic [wtr_pkg::CNT_W-1:0]        rsp_samples_ff, rsp_samples_in;
   logic [wtr_pkg::CNT_W-1:0]        rsp_hits_ff, rsp_hits_in;
   logic                             rsp_overflow_ff, rsp_overflow_in;

   logic                             ram_wr_en;
   logic [$bits(wtr_pkg::sample_type)-1:0] ram_rd_data;
   wtr_pkg::sample_type              rd_sample;
   logic [wtr_pkg::SUM_W-1:0]        tail_sum;
   logic [wtr_pkg::PTR_W-1:0]        tail_ptr;
   logic [wtr_pkg::PTR_W-1:0]        head_next_ptr;
   logic [wtr_pkg::TS_W-1:0]         age;
   logic                             expired;
   logic                             full;
   logic                             drop_hit;
   logic                             rsp_free;

   logic                             div_start;
   logic                             div_done;
   logic [wtr_pkg::TOTAL_W-1:0]      div_numer;
   logic [wtr_pkg::TOTAL_W-1:0]      div_denom;
   logic [wtr_pkg::RATIO_W-1:0]      div_quotient;

   wtr_ram #(
      .WIDTH ($bits(wtr_pkg::sample_type)),
      .DEPTH (wtr_pkg::WINDOW_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ptr),
      .wr_data (cur_ff),
      .rd_addr (head_ptr_ff),
      .rd_data (ram_rd_data)
   );

   wtr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      rd_sample     = wtr_pkg::sample_type'(ram_rd_data);
      tail_sum      = wtr_pkg::SUM_W'(head_ptr_ff) + wtr_pkg::SUM_W'(occ_ff);
      tail_ptr      = (tail_sum >= wtr_pkg::SUM_W'(wtr_pkg::WINDOW_DEPTH)) ?
                      wtr_pkg::PTR_W'(tail_sum - wtr_pkg::SUM_W'(wtr_pkg::WINDOW_DEPTH)) :
                      wtr_pkg::PTR_W'(tail_sum);
      head_next_ptr = (head_ptr_ff == wtr_pkg::PTR_W'(wtr_pkg::WINDOW_DEPTH - 1)) ?
                      '0 : head_ptr_ff + 1'b1;
      age           = cur_ff.timestamp - rd_sample.timestamp;
      expired       = (occ_ff != '0) && (age > window_length);
      full          = occ_ff == wtr_pkg::CNT_W'(wtr_pkg::WINDOW_DEPTH);
      drop_hit      = rd_sample.hit && (hits_ff != '0);
      rsp_free      = !rsp_valid_ff || rsp_chan.ready;
      div_numer     = (state_ff == wtr_pkg::BACK_PRUNE) ?
                      wtr_pkg::TOTAL_W'(hits_ff) : total_hits_ff;
      div_denom     = (state_ff == wtr_pkg::BACK_PRUNE) ?
                      wtr_pkg::TOTAL_W'(occ_ff) : total_samples_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wtr_pkg::BACK_IDLE: begin
            if (queue_out.valid) begin
               state_in = wtr_pkg::BACK_FULL;
            end
         end
         wtr_pkg::BACK_FULL:   state_in = wtr_pkg::BACK_SETTLE;
         wtr_pkg::BACK_SETTLE: state_in = wtr_pkg::BACK_PRUNE;
         wtr_pkg::BACK_PRUNE: begin
            state_in = expired ? wtr_pkg::BACK_SETTLE : wtr_pkg::BACK_WDIV;
         end
         wtr_pkg::BACK_WDIV: begin
            if (div_done) begin
               state_in = wtr_pkg::BACK_GDIV;
            end
         end
         wtr_pkg::BACK_GDIV: begin
            if (div_done) begin
               state_in = wtr_pkg::BACK_EMIT;
            end
         end
         wtr_pkg::BACK_EMIT: begin
            if (rsp_free) begin
               state_in = wtr_pkg::BACK_IDLE;
            end
         end
         default: state_in = wtr_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      pop                 = 1'b0;
      ram_wr_en           = 1'b0;
      div_start           = 1'b0;
      cur_in              = cur_ff;
      over_in             = over_ff;
      head_ptr_in         = head_ptr_ff;
      occ_in              = occ_ff;
      hits_in             = hits_ff;
      total_samples_in    = total_samples_ff;
      total_hits_in       = total_hits_ff;
      window_ratio_in     = window_ratio_ff;
      global_ratio_in     = global_ratio_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_chan.ready;
      rsp_window_ratio_in = rsp_window_ratio_ff;
      rsp_global_ratio_in = rsp_global_ratio_ff;
      rsp_samples_in      = rsp_samples_ff;
      rsp_hits_in         = rsp_hits_ff;
      rsp_overflow_in     = rsp_overflow_ff;
      unique case (state_ff)
         wtr_pkg::BACK_IDLE: begin
            pop    = queue_out.valid;
            cur_in = queue_out.sample;
         end
         wtr_pkg::BACK_FULL: begin
            ram_wr_en = 1'b1;
            over_in   = full;
            if (full) begin
               head_ptr_in = head_next_ptr;
            end else begin
               occ_in = occ_ff + 1'b1;
            end
            hits_in = hits_ff - wtr_pkg::CNT_W'(full && drop_hit)
                      + wtr_pkg::CNT_W'(cur_ff.hit);
            if (total_samples_ff != wtr_pkg::TOTAL_MAX) begin
               total_samples_in = total_samples_ff + 1'b1;
            end
            if (cur_ff.hit && (total_hits_ff != wtr_pkg::TOTAL_MAX)) begin
               total_hits_in = total_hits_ff + 1'b1;
            end
         end
         wtr_pkg::BACK_SETTLE: begin
         end
         wtr_pkg::BACK_PRUNE: begin
            if (expired) begin
               head_ptr_in = head_next_ptr;
               occ_in      = occ_ff - 1'b1;
               hits_in     = hits_ff - wtr_pkg::CNT_W'(drop_hit);
            end else begin
               div_start = 1'b1;
            end
         end
         wtr_pkg::BACK_WDIV: begin
            if (div_done) begin
               window_ratio_in = div_quotient;
               div_start       = 1'b1;
            end
         end
         wtr_pkg::BACK_GDIV: begin
            if (div_done) begin
               global_ratio_in = div_quotient;
            end
         end
         wtr_pkg::BACK_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_window_ratio_in = window_ratio_ff;
               rsp_global_ratio_in = global_ratio_ff;
               rsp_samples_in      = occ_ff;
               rsp_hits_in         = hits_ff;
               rsp_overflow_in     = over_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= wtr_pkg::BACK_IDLE;
         head_ptr_ff      <= '0;
         occ_ff           <= '0;
         hits_ff          <= '0;
         total_samples_ff <= '0;
         total_hits_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         head_ptr_ff      <= head_ptr_in;
         occ_ff           <= occ_in;
         hits_ff          <= hits_in;
         total_samples_ff <= total_samples_in;
         total_hits_ff    <= total_hits_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      cur_ff              <= cur_in;
      over_ff             <= over_in;
      window_ratio_ff     <= window_ratio_in;
      global_ratio_ff     <= global_ratio_in;
      rsp_window_ratio_ff <= rsp_window_ratio_in;
      rsp_global_ratio_ff <= rsp_global_ratio_in;
      rsp_samples_ff      <= rsp_samples_in;
      rsp_hits_ff         <= rsp_hits_in;
      rsp_overflow_ff     <= rsp_overflow_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.window_ratio   = rsp_window_ratio_ff;
   assign rsp_chan.global_ratio   = rsp_global_ratio_ff;
   assign rsp_chan.window_samples = rsp_samples_ff;
   assign rsp_chan.window_hits    = rsp_hits_ff;
   assign rsp_chan.overflow       = rsp_overflow_ff;

`ifndef SYNTH
   a_hits_le_occ: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= occ_ff)
      else $error("window hit count above occupancy");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= wtr_pkg::CNT_W'(wtr_pkg::WINDOW_DEPTH))
      else $error("window occupancy above depth");

   a_newest_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wtr_pkg::BACK_PRUNE) |-> (occ_ff != '0))
      else $error("pruning emptied the window");
`endif

endmodule

### rtl/windowed_threshold_ratio_unit.sv
// Sliding time-window hit ratio.
// req_chan carries one request per sample: timestamp_ms (nondecreasing, wraps)
// and score (unsigned Q0.16). A score above hit_threshold marks the sample a hit.
// rsp_chan returns exactly one result per request, in order: window and
// lifetime hit ratios (Q1.16, 65536 means all), window occupancy, window hits
// and an overflow flag set when the 64-entry window dropped its oldest sample.
// csr_write_enable/csr_index/csr_write_data write window_length_ms (index 0)
// and hit_threshold (index 1); write only while no request is in flight.
// A two-entry queue takes requests while the back end works; the back end
// handles one request at a time and prunes expired samples one by one. Two
// 17-step serial divisions follow, for the window and the lifetime ratios.
// A stalled receiver holds the result register; the back end completes the
// next request and waits, then the queue fills and req ready drops.
// Reset (synchronous, active high) empties the window and queue, clears the
// lifetime totals and restores window_length_ms = 1000, hit_threshold = 19660.
module windowed_threshold_ratio_unit (
   input  logic                              clock,
   input  logic                              reset,
   wtr_req_if.sink                           req_chan,
   wtr_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [wtr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wtr_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic [wtr_pkg::TS_W-1:0]      window_length_ff, window_length_in;
   logic [wtr_pkg::SCORE_W-1:0]   hit_threshold_ff, hit_threshold_in;
   wtr_pkg::queue_out_type        queue_out;
   logic                          pop;

   always_comb begin
      window_length_in = window_length_ff;
      hit_threshold_in = hit_threshold_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            wtr_pkg::CSR_WINDOW_LENGTH:
               window_length_in = csr_write_data[wtr_pkg::TS_W-1:0];
            wtr_pkg::CSR_HIT_THRESHOLD:
               hit_threshold_in = csr_write_data[wtr_pkg::SCORE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= wtr_pkg::WINDOW_LENGTH_RESET;
         hit_threshold_ff <= wtr_pkg::HIT_THRESHOLD_RESET;
      end else begin
         window_length_ff <= window_length_in;
         hit_threshold_ff <= hit_threshold_in;
      end
   end

   wtr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .hit_threshold (hit_threshold_ff),
      .pop           (pop),
      .queue_out     (queue_out)
   );

   wtr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_out     (queue_out),
      .pop           (pop),
      .window_length (window_length_ff),
      .rsp_chan      (rsp_chan)
   );

endmodule
